@@ rtl/arest_pkg.sv @@
// ============================================================================
// arest_pkg : shared types and constants for the angle rate estimator
// Sequencer states, datapath widths and fixed-point constants.
// ============================================================================
`default_nettype none

package arest_pkg;

   // Field widths fixed by the beat format
   localparam int unsigned ANGLE_WIDTH    = 17;
   localparam int unsigned YAW_WIDTH      = 20;
   localparam int unsigned RATE_WIDTH     = 32;
   localparam int unsigned ALPHA_WIDTH    = 17;
   localparam int unsigned STAMP_WIDTH    = 32;

   // |angle difference| * 1000 stays below 2^27
   localparam int unsigned DIVIDEND_WIDTH = 27;
   localparam int unsigned RAW_WIDTH      = DIVIDEND_WIDTH + 1;

   // Filter arithmetic widths
   localparam int unsigned DELTA_WIDTH    = 36;
   localparam int unsigned PROD_WIDTH     = DELTA_WIDTH + ALPHA_WIDTH + 1;
   localparam int unsigned STEP_WIDTH     = PROD_WIDTH - 16;
   localparam int unsigned SUM_WIDTH      = STEP_WIDTH + 1;

   localparam logic [ALPHA_WIDTH-1:0]    ALPHA_ONE  = 17'd65536;
   localparam logic [DIVIDEND_WIDTH-1:0] MS_PER_S   = 27'd1000;
   localparam logic [PROD_WIDTH-1:0]     ROUND_HALF = PROD_WIDTH'(32768);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MULT,
      ST_ACCUM,
      ST_EMIT
   } seq_state_type;

endpackage

`default_nettype wire

@@ rtl/arest_div.sv @@
// ============================================================================
// arest_div : iterative unsigned divider
// Restoring division, one quotient bit per cycle, MSB first.
// ============================================================================
`default_nettype none

module arest_div #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    div_start,
   input  wire logic [arest_pkg::DIVIDEND_WIDTH-1:0]    div_dividend,
   input  wire logic [TIME_WIDTH-1:0]                   div_divisor,
   output logic      [arest_pkg::DIVIDEND_WIDTH-1:0]    div_quotient,
   output logic                                         div_done
);

   localparam int unsigned DW    = arest_pkg::DIVIDEND_WIDTH;
   localparam int unsigned CNT_W = $clog2(DW);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [TIME_WIDTH-1:0] rem_ff;
   logic [TIME_WIDTH-1:0] divisor_ff;
   logic [DW-1:0]    quo_ff;

   logic [TIME_WIDTH:0]   trial;
   logic [TIME_WIDTH:0]   diff;
   logic                  qbit;
   logic [TIME_WIDTH-1:0] rem_in;

   // one restoring step: shift in next dividend bit, try subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[DW-1]};
      diff   = trial - {1'b0, divisor_ff};
      qbit   = ~diff[TIME_WIDTH];
      rem_in = qbit ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DW - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: quo_ff shifts remaining dividend bits out at the top, quotient bits in at the bottom
   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff     <= '0;
         quo_ff     <= div_dividend;
         divisor_ff <= div_divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DW-2:0], qbit};
      end
   end

   assign div_quotient = quo_ff;
   assign div_done     = done_ff;

endmodule

`default_nettype wire

@@ rtl/angle_rate_estimator_ema.sv @@
// ============================================================================
// angle_rate_estimator_ema : roll/pitch rate from angle differences, EMA
// Finite-difference rate estimate with a first-order smoothing filter.
// ============================================================================
// Each beat carries one attitude sample; angles, yaw rate and flags pass
// through, and the roll and pitch rates are (angle delta * 1000 / elapsed ms),
// smoothed by filt += alpha * (raw - filt) / 65536 and saturated to 32 bits.
// Items are processed one at a time and req_stall is high while one is in
// flight. An invalid sample goes through setup and emit, then back to idle.
// A valid sample runs both axes through one shared bit-serial divider and
// one shared multiplier; each axis takes the setup, divide, multiply and
// accumulate states in turn, and the result beat is loaded in the emit state
// after the pitch axis. When no division is needed (no previous valid
// sample, or the timestamp did not advance) the divide state is skipped. A
// stalled result beat holds the sequencer in its emit state for as long as
// the stall lasts.
// rate_alpha is written through csr_wr_en/csr_wr_data; the user must write
// it only while idle, which the block itself does not enforce. Values
// above 65536 are clamped to 65536.
`default_nettype none

module angle_rate_estimator_ema #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    csr_wr_en,
   input  wire logic        [arest_pkg::ALPHA_WIDTH-1:0] csr_wr_data,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic        [arest_pkg::STAMP_WIDTH-1:0] req_now_ms,
   input  wire logic signed [arest_pkg::ANGLE_WIDTH-1:0] req_roll_angle,
   input  wire logic signed [arest_pkg::ANGLE_WIDTH-1:0] req_pitch_angle,
   input  wire logic signed [arest_pkg::YAW_WIDTH-1:0]   req_yaw_rate_in,
   input  wire logic                                    req_sample_valid,
   input  wire logic                                    req_sample_fresh,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed      [arest_pkg::ANGLE_WIDTH-1:0] rsp_roll_out,
   output logic signed      [arest_pkg::ANGLE_WIDTH-1:0] rsp_pitch_out,
   output logic signed      [arest_pkg::YAW_WIDTH-1:0]   rsp_yaw_rate_out,
   output logic signed      [arest_pkg::RATE_WIDTH-1:0]  rsp_roll_rate,
   output logic signed      [arest_pkg::RATE_WIDTH-1:0]  rsp_pitch_rate,
   output logic                                         rsp_valid_out,
   output logic                                         rsp_fresh_out
);

   localparam int unsigned AW   = arest_pkg::ANGLE_WIDTH;
   localparam int unsigned YW   = arest_pkg::YAW_WIDTH;
   localparam int unsigned RW   = arest_pkg::RATE_WIDTH;
   localparam int unsigned DW   = arest_pkg::DIVIDEND_WIDTH;
   localparam int unsigned QW   = arest_pkg::RAW_WIDTH;
   localparam int unsigned TW   = arest_pkg::DELTA_WIDTH;
   localparam int unsigned PW   = arest_pkg::PROD_WIDTH;
   localparam int unsigned SW   = arest_pkg::STEP_WIDTH;
   localparam int unsigned UW   = arest_pkg::SUM_WIDTH;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   arest_pkg::seq_state_type state_ff, state_in;

   logic [arest_pkg::ALPHA_WIDTH-1:0] alpha_ff;

   logic [TIME_WIDTH-1:0] last_time_ff;
   logic                  have_prev_ff;
   logic signed [AW-1:0]  prev_roll_ff;
   logic signed [AW-1:0]  prev_pitch_ff;
   logic signed [RW-1:0]  roll_filt_ff;
   logic signed [RW-1:0]  pitch_filt_ff;

   logic [TIME_WIDTH-1:0] now_ff;
   logic signed [AW-1:0]  cap_roll_ff;
   logic signed [AW-1:0]  cap_pitch_ff;
   logic signed [YW-1:0]  cap_yaw_ff;
   logic                  cap_valid_ff;
   logic                  cap_fresh_ff;
   logic                  use_div_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff;

   logic                  lane_ff;
   logic                  neg_ff;
   logic signed [QW-1:0]  raw_ff;
   logic signed [PW-1:0]  prod_ff;

   logic                  rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------------
   // combinational datapath
   // ---------------------------------------------------------------------
   logic [TIME_WIDTH-1:0] now_masked;
   logic                  req_take;
   logic                  out_free;
   logic                  emit_load;

   logic signed [AW-1:0]  cur_angle;
   logic signed [AW-1:0]  prev_angle;
   logic signed [AW:0]    angle_diff;
   logic        [AW:0]    angle_abs;
   logic        [DW-1:0]  dividend;
   logic signed [RW-1:0]  filt_cur;
   logic signed [TW-1:0]  delta;
   logic signed [PW-1:0]  rounded;
   logic signed [SW-1:0]  step;
   logic signed [UW-1:0]  sum;
   logic signed [RW-1:0]  filt_new;

   logic                  div_start;
   logic                  div_done;
   logic        [DW-1:0]  div_quotient;

   assign now_masked = req_now_ms[TIME_WIDTH-1:0];
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_load  = (state_ff == arest_pkg::ST_EMIT) && out_free;

   // angle difference magnitude times 1000 for the current axis
   always_comb begin
      cur_angle  = lane_ff ? cap_pitch_ff : cap_roll_ff;
      prev_angle = lane_ff ? prev_pitch_ff : prev_roll_ff;
      angle_diff = {cur_angle[AW-1], cur_angle} - {prev_angle[AW-1], prev_angle};
      angle_abs  = angle_diff[AW] ? (AW+1)'(-angle_diff) : angle_diff;
      dividend   = {{(DW-AW){1'b0}}, angle_abs[AW-1:0]} * arest_pkg::MS_PER_S;
   end

   // filter update: filt + floor((alpha * (raw - filt) + 2^15) / 2^16), saturated
   always_comb begin
      filt_cur = lane_ff ? pitch_filt_ff : roll_filt_ff;
      delta    = {{(TW-QW){raw_ff[QW-1]}}, raw_ff} - {{(TW-RW){filt_cur[RW-1]}}, filt_cur};
      rounded  = prod_ff + $signed(arest_pkg::ROUND_HALF);
      step     = rounded[PW-1:16];
      sum      = {{(UW-RW){filt_cur[RW-1]}}, filt_cur} + {step[SW-1], step};
      if (sum[UW-1:RW-1] == '0 || sum[UW-1:RW-1] == '1) begin
         filt_new = sum[RW-1:0];
      end else if (sum[UW-1]) begin
         filt_new = {1'b1, {(RW-1){1'b0}}};
      end else begin
         filt_new = {1'b0, {(RW-1){1'b1}}};
      end
   end

   // ---------------------------------------------------------------------
   // shared divider
   // ---------------------------------------------------------------------
   arest_div #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (dividend),
      .div_divisor  (elapsed_ff),
      .div_quotient (div_quotient),
      .div_done     (div_done)
   );

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arest_pkg::ST_IDLE: begin
            if (req_take) state_in = arest_pkg::ST_SETUP;
         end
         arest_pkg::ST_SETUP: begin
            if (!cap_valid_ff)   state_in = arest_pkg::ST_EMIT;
            else if (use_div_ff) state_in = arest_pkg::ST_DIVIDE;
            else                 state_in = arest_pkg::ST_MULT;
         end
         arest_pkg::ST_DIVIDE: begin
            if (div_done) state_in = arest_pkg::ST_MULT;
         end
         arest_pkg::ST_MULT: begin
            state_in = arest_pkg::ST_ACCUM;
         end
         arest_pkg::ST_ACCUM: begin
            state_in = lane_ff ? arest_pkg::ST_EMIT : arest_pkg::ST_SETUP;
         end
         arest_pkg::ST_EMIT: begin
            if (out_free) state_in = arest_pkg::ST_IDLE;
         end
         default: state_in = arest_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      unique case (state_ff)
         arest_pkg::ST_IDLE:  req_stall = 1'b0;
         arest_pkg::ST_SETUP: div_start = cap_valid_ff && use_div_ff;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = emit_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arest_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         alpha_ff      <= arest_pkg::ALPHA_ONE;
         have_prev_ff  <= 1'b0;
         last_time_ff  <= '0;
         prev_roll_ff  <= '0;
         prev_pitch_ff <= '0;
         roll_filt_ff  <= '0;
         pitch_filt_ff <= '0;
         lane_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;

         // alpha register, clamped to one
         if (csr_wr_en) begin
            alpha_ff <= (csr_wr_data > arest_pkg::ALPHA_ONE) ?
                        arest_pkg::ALPHA_ONE : csr_wr_data;
         end

         if (req_take) lane_ff <= 1'b0;

         // per-axis filter update
         if (state_ff == arest_pkg::ST_ACCUM) begin
            if (lane_ff) pitch_filt_ff <= filt_new;
            else         roll_filt_ff  <= filt_new;
            lane_ff <= 1'b1;
         end

         // commit sample state when the result beat is loaded
         if (emit_load) begin
            last_time_ff <= now_ff;
            have_prev_ff <= cap_valid_ff;
            if (cap_valid_ff) begin
               prev_roll_ff  <= cap_roll_ff;
               prev_pitch_ff <= cap_pitch_ff;
            end else begin
               roll_filt_ff  <= '0;
               pitch_filt_ff <= '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // capture input beat
      if (req_take) begin
         now_ff       <= now_masked;
         cap_roll_ff  <= req_roll_angle;
         cap_pitch_ff <= req_pitch_angle;
         cap_yaw_ff   <= req_yaw_rate_in;
         cap_valid_ff <= req_sample_valid;
         cap_fresh_ff <= req_sample_fresh;
         use_div_ff   <= have_prev_ff && (now_masked > last_time_ff);
         elapsed_ff   <= now_masked - last_time_ff;
      end

      // raw rate: zero when no division, signed quotient otherwise
      if (state_ff == arest_pkg::ST_SETUP) begin
         neg_ff <= angle_diff[AW];
         raw_ff <= '0;
      end else if (state_ff == arest_pkg::ST_DIVIDE && div_done) begin
         raw_ff <= neg_ff ? QW'(-$signed({1'b0, div_quotient})) :
                            $signed({1'b0, div_quotient});
      end

      // shared multiplier
      if (state_ff == arest_pkg::ST_MULT) begin
         prod_ff <= PW'($signed({1'b0, alpha_ff}) * delta);
      end

      // result beat
      if (emit_load) begin
         rsp_roll_out     <= cap_roll_ff;
         rsp_pitch_out    <= cap_pitch_ff;
         rsp_yaw_rate_out <= cap_yaw_ff;
         rsp_roll_rate    <= cap_valid_ff ? roll_filt_ff : '0;
         rsp_pitch_rate   <= cap_valid_ff ? pitch_filt_ff : '0;
         rsp_valid_out    <= cap_valid_ff;
         rsp_fresh_out    <= cap_fresh_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
